/* sv/cts_pkg.sv */
// Shared types and constants for the compressor thermostat.
// Mode encoding, register indexes, reset values and the settings struct.
// No dependencies.
package cts_pkg;

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_COOLING = 3'd1,
    MODE_PAUSE   = 3'd2,
    MODE_WARMING = 3'd3,
    MODE_ERROR   = 3'd4
  } mode_t;

  localparam int unsigned TEMP_W = 8;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLING_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_TICKS = 3'd5;

  localparam logic [TEMP_W-1:0] RST_TARGET_TEMP = 8'd0;
  localparam logic [TEMP_W-1:0] RST_HYSTERESIS = 8'd1;
  localparam logic [SAMPLE_W-1:0] RST_ERROR_CODE = 16'hFFFF;
  localparam logic [TICK_W-1:0] RST_COOLING_MAX = 16'(20 * 60 * 10);
  localparam logic [TICK_W-1:0] RST_PAUSE_TICKS = 16'(2 * 60 * 10);
  localparam logic [TICK_W-1:0] RST_INIT_TICKS = 16'(2 * 60 * 10);

  typedef struct packed {
    logic [TEMP_W-1:0]   target_temp;
    logic [TEMP_W-1:0]   hysteresis;
    logic [SAMPLE_W-1:0] error_code;
    logic [TICK_W-1:0]   cooling_max_ticks;
    logic [TICK_W-1:0]   pause_ticks;
    logic [TICK_W-1:0]   init_ticks;
  } cts_cfg_t;

endpackage

/* sv/compressor_thermostat_fsm_unit.sv */
// Compressor thermostat: stream wrapper, settings registers and item handshake.
// Instantiates cts_ctrl; depends on cts_pkg.
//
// Usage:
//   Input channel in_*: one item per 100 ms tick, in_tdata[15:0] = temp_sample.
//   Result channel out_*: one result per input item,
//     out_tdata[0] = compressor_on, out_tdata[3:1] = mode, upper bits zero.
//   Settings port cfg_*: cfg_we writes cfg_wdata to register cfg_index
//     (0 target_temp, 1 hysteresis, 2 error_code, 3 cooling_max_ticks,
//     4 pause_ticks, 5 init_ticks); other indexes are ignored. Write only
//     while no item is in flight.
// Timing:
//   An item is registered on acceptance; the mode machine steps when that item
//   advances, which a stall can delay, updating the state registers that drive
//   out_tdata. out_tvalid is registered on the step; one item per cycle sustained while out_tready stays high.
//   The mode machine step is the only logic between the two registers.
// Reset:
//   Synchronous, active low. Mode init, counter zero, relay off, settings at
//   their defaults, both channels empty.
// Stall:
//   While out_tready is low the result holds, at most one further item is taken into
//   the input register, then in_tready drops until the result is taken.
module compressor_thermostat_fsm_unit import cts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] temp_sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] compressor_on, [3:1] mode
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cts_cfg_t            cfg_r;
  logic                in_valid_r, in_valid_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic                out_valid_r, out_valid_nxt;
  logic                advance;
  logic                relay;
  mode_t               mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_temp       <= RST_TARGET_TEMP;
      cfg_r.hysteresis        <= RST_HYSTERESIS;
      cfg_r.error_code        <= RST_ERROR_CODE;
      cfg_r.cooling_max_ticks <= RST_COOLING_MAX;
      cfg_r.pause_ticks       <= RST_PAUSE_TICKS;
      cfg_r.init_ticks        <= RST_INIT_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_TEMP: cfg_r.target_temp       <= cfg_wdata[TEMP_W-1:0];
        CFG_HYSTERESIS:  cfg_r.hysteresis        <= cfg_wdata[TEMP_W-1:0];
        CFG_ERROR_CODE:  cfg_r.error_code        <= cfg_wdata[SAMPLE_W-1:0];
        CFG_COOLING_MAX: cfg_r.cooling_max_ticks <= cfg_wdata[TICK_W-1:0];
        CFG_PAUSE_TICKS: cfg_r.pause_ticks       <= cfg_wdata[TICK_W-1:0];
        CFG_INIT_TICKS:  cfg_r.init_ticks        <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
    else if (advance)           in_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance)         out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) sample_r <= in_tdata[SAMPLE_W-1:0];
  end

  cts_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .sample (sample_r),
    .cfg    (cfg_r),
    .relay  (relay),
    .mode   (mode)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, mode, relay};

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(sample_r))
    else $error("buffered item lost under stall");

  a_result_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("stepped item produced no result");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_tdata))
    else $error("waiting result changed");

endmodule

/* sv/cts_ctrl.sv */
// Thermostat mode machine: mode, tick down-counter and relay state.
// Advances once per item on the step strobe.
// Depends on cts_pkg.
module cts_ctrl import cts_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [SAMPLE_W-1:0] sample,
  input  cts_cfg_t            cfg,
  output logic                relay,
  output mode_t               mode
);

  mode_t               mode_r, mode_nxt;
  logic [TICK_W-1:0]   cnt_r, cnt_nxt, cnt_dec;
  logic                relay_r, relay_nxt;
  logic                err_hit, expired, too_cold, too_warm;
  logic [TEMP_W-1:0]   low_bound;
  logic [TEMP_W:0]     high_bound;

  assign err_hit    = (sample == cfg.error_code);
  assign cnt_dec    = (cnt_r == '0) ? '0 : cnt_r - TICK_W'(1);
  assign expired    = (cnt_dec == '0);
  assign low_bound  = cfg.target_temp - cfg.hysteresis;
  assign high_bound = {1'b0, cfg.target_temp} + {1'b0, cfg.hysteresis};
  assign too_cold   = (cfg.target_temp >= cfg.hysteresis) &&
                      ({{(SAMPLE_W-TEMP_W){1'b0}}, low_bound} > sample);
  assign too_warm   = ({{(SAMPLE_W-TEMP_W-1){1'b0}}, high_bound} < sample);

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    if (err_hit) begin
      mode_nxt = MODE_ERROR;
    end else begin
      unique case (mode_r) inside
        MODE_INIT, MODE_PAUSE: begin
          if (expired && too_cold) mode_nxt = MODE_WARMING;
          else if (expired && too_warm) mode_nxt = MODE_COOLING;
        end
        MODE_COOLING: begin
          if (expired) mode_nxt = MODE_PAUSE;
          else if (too_cold) mode_nxt = MODE_WARMING;
        end
        MODE_WARMING: begin
          if (too_warm) mode_nxt = MODE_COOLING;
        end
        MODE_ERROR: mode_nxt = MODE_INIT;
        default:    mode_nxt = mode_r;
      endcase
    end
  end

  // relay and counter on mode entry; otherwise the counter counts down to zero and the relay holds
  always_comb begin
    relay_nxt = relay_r;
    cnt_nxt   = cnt_dec;
    if (mode_nxt != mode_r) begin
      unique case (mode_nxt)
        MODE_COOLING: begin
          relay_nxt = 1'b1;
          cnt_nxt   = cfg.cooling_max_ticks;
        end
        MODE_PAUSE: begin
          relay_nxt = 1'b0;
          cnt_nxt   = cfg.pause_ticks;
        end
        MODE_INIT: begin
          relay_nxt = 1'b0;
          cnt_nxt   = cfg.init_ticks;
        end
        default: relay_nxt = 1'b0;
      endcase
    end else if (mode_r == MODE_ERROR) begin
      relay_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_INIT;
      cnt_r   <= '0;
      relay_r <= 1'b0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      relay_r <= relay_nxt;
    end
  end

  assign relay = relay_r;
  assign mode  = mode_r;

  a_relay_only_cooling: assert property (@(posedge clk) disable iff (!rst_n)
    relay_r |-> (mode_r == MODE_COOLING))
    else $error("relay on outside cooling");

  a_error_sample: assert property (@(posedge clk) disable iff (!rst_n)
    step && err_hit |=> (mode_r == MODE_ERROR) && !relay_r)
    else $error("fault sample did not enter error mode");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(mode_r) && $stable(cnt_r) && $stable(relay_r))
    else $error("state moved without an item");

  a_cool_load: assert property (@(posedge clk) disable iff (!rst_n)
    step && (mode_nxt == MODE_COOLING) && (mode_r != MODE_COOLING)
      |=> (cnt_r == $past(cfg.cooling_max_ticks)))
    else $error("cooling entry did not load run limit");

endmodule
